[design/bsa_pkg.sv]
// Shared types, codes and defaults for the bitmap slot allocator.
// No dependencies; every other design file imports this package.
package bsa_pkg;

  // Default geometry of the free map.
  localparam int DEF_WORD_BITS = 64;
  localparam int DEF_MAP_WORDS = 64;

  // Fixed field widths.
  localparam int SLOT_W      = 32;
  localparam int NUM_SLOTS_W = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CMD_W       = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLOTS  = 1'b1;

  // Request commands; the unused code answers out of range.
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_AT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_TAKEN  = 3'd3,
    ST_DOUBLE = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EVAL
  } state_t;

  // One result as it leaves the core.
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } result_t;

  // Address width of a memory of the given depth (at least one bit).
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[design/bsa_map_ram.sv]
// Free-map storage: one write port and one registered read port.
// Depends on bsa_pkg for the address width helper.
module bsa_map_ram #(
  parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS,
  parameter int MAP_WORDS = bsa_pkg::DEF_MAP_WORDS
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [bsa_pkg::addr_w(MAP_WORDS)-1:0]      waddr,
  input  logic [WORD_BITS-1:0]                       wdata,
  input  logic [bsa_pkg::addr_w(MAP_WORDS)-1:0]      raddr,
  output logic [WORD_BITS-1:0]                       rdata
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/bsa_core.sv]
// Sequencer and shared datapath of the slot allocator: map init sweep,
// next-fit word scan, slot-to-word split and bit update.
// Depends on bsa_pkg; drives the free-map memory through its ports.
module bsa_core #(
  parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS,
  parameter int MAP_WORDS = bsa_pkg::DEF_MAP_WORDS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [bsa_pkg::CMD_W-1:0]                  cmd,
  input  logic [bsa_pkg::SLOT_W-1:0]                 slot_in,
  input  logic [bsa_pkg::SLOT_W-1:0]                 slot_base,
  input  logic [bsa_pkg::NUM_SLOTS_W-1:0]            slot_total,
  input  logic                                       init_req,
  output logic                                       ram_we,
  output logic [bsa_pkg::addr_w(MAP_WORDS)-1:0]      ram_waddr,
  output logic [WORD_BITS-1:0]                       ram_wdata,
  output logic [bsa_pkg::addr_w(MAP_WORDS)-1:0]      ram_raddr,
  input  logic [WORD_BITS-1:0]                       ram_rdata,
  output bsa_pkg::result_t                           res
);
  import bsa_pkg::*;

  localparam int CAP   = WORD_BITS * MAP_WORDS;
  localparam int CAP_W = $clog2(CAP + 1);
  localparam int CNT_W = (CAP_W > NUM_SLOTS_W) ? CAP_W : NUM_SLOTS_W;
  localparam int AW    = $clog2(MAP_WORDS + 1);
  localparam int WA    = addr_w(MAP_WORDS);
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int PAD   = 2 ** BIT_W;
  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  // Position of the highest set bit, found by halving the word.
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
    logic [PAD-1:0]   cur;
    logic [BIT_W-1:0] pos;
    cur = PAD'(v);
    pos = '0;
    for (int i = BIT_W - 1; i >= 0; i--) begin
      if ((cur >> (2 ** i)) != '0) begin
        pos[i] = 1'b1;
        cur    = cur >> (2 ** i);
      end
    end
    return pos;
  endfunction

  state_t              state_r, state_nxt;
  logic [WA-1:0]       w_r, w_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       act_r, act_nxt;
  logic [BIT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [WA-1:0]       scan_r, scan_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  result_t             res_r, res_nxt;

  logic [CNT_W-1:0]    num_ext;
  logic [CNT_W-1:0]    eff;
  logic [SLOT_W-1:0]   idx;
  logic                in_range;
  logic [CNT_W:0]      alu_out;
  logic [CNT_W-1:0]    diff;
  logic                ge;
  logic [WORD_BITS-1:0] init_word;
  logic [BIT_W-1:0]    hi_bit;
  logic [BIT_W-1:0]    bit_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic                is_free;

  // Managed slot count, saturated to the map capacity.
  assign num_ext  = CNT_W'(slot_total);
  assign eff      = (num_ext > CNT_W'(CAP)) ? CNT_W'(CAP) : num_ext;

  // Offset of a named slot from bit zero, modulo 2^32.
  assign idx      = slot_in - slot_base;
  assign in_range = idx < SLOT_W'(eff);

  // Init subtractor: managed slots left above the base of the current word.
  assign alu_out = {1'b0, eff} - {1'b0, base_r};
  assign diff    = alu_out[CNT_W-1:0];
  assign ge      = ~alu_out[CNT_W];

  // Init value of the current word: free bits below the slot count.
  always_comb begin
    if (!ge) begin
      init_word = '0;
    end else if (diff >= CNT_W'(WORD_BITS)) begin
      init_word = ALL_ONES;
    end else begin
      init_word = ~(ALL_ONES << diff[BIT_W-1:0]);
    end
  end

  // Bit selection on the word just read.
  assign hi_bit   = top_bit(ram_rdata);
  assign bit_pos  = rem_r;
  assign bit_mask = WORD_BITS'(1) << ((cmd_r == CMD_ALLOC) ? hi_bit : bit_pos);
  assign is_free  = (ram_rdata & bit_mask) != '0;

  assign ram_raddr = w_r;
  assign busy      = (state_r != S_IDLE);
  assign res       = res_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      w_r       <= '0;
      k_r       <= '0;
      act_r     <= '0;
      base_r    <= '0;
      scan_r    <= '0;
      res_r.valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      w_r       <= w_nxt;
      k_r       <= k_nxt;
      act_r     <= act_nxt;
      base_r    <= base_nxt;
      scan_r    <= scan_nxt;
      res_r.valid <= res_nxt.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    res_r.status <= res_nxt.status;
    res_r.slot   <= res_nxt.slot;
  end

  // Sequencer: next state, memory writes and results.
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    k_nxt         = k_r;
    act_nxt       = act_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    scan_nxt      = scan_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    res_nxt       = res_r;
    res_nxt.valid = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = w_r;
    ram_wdata     = '0;

    case (state_r)
      S_INIT: begin
        // Sweep every word once, counting the words that hold managed slots.
        ram_we    = 1'b1;
        ram_wdata = init_word;
        base_nxt  = base_r + CNT_W'(WORD_BITS);
        if (ge && (diff != '0)) begin
          act_nxt = act_r + AW'(1);
        end
        if (w_r == WA'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + WA'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt  = cmd;
          slot_nxt = slot_in;
          res_nxt.slot = slot_in;
          case (cmd)
            CMD_ALLOC: begin
              if (act_r == '0) begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = ST_FULL;
              end else begin
                w_nxt     = (AW'(scan_r) < act_r) ? scan_r : '0;
                k_nxt     = '0;
                state_nxt = S_RD;
              end
            end
            CMD_ALLOC_AT, CMD_FREE: begin
              if (in_range) begin
                // Word index and bit position of the offset.
                rem_nxt   = idx[BIT_W-1:0];
                w_nxt     = WA'(idx >> BIT_W);
                state_nxt = S_RD;
              end else begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = ST_RANGE;
              end
            end
            default: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = ST_RANGE;
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (cmd_r == CMD_ALLOC) begin
          if (ram_rdata != '0) begin
            // Grant the highest free bit of this word.
            ram_we         = 1'b1;
            ram_wdata      = ram_rdata & ~bit_mask;
            scan_nxt       = w_r;
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_OK;
            res_nxt.slot   = slot_base + SLOT_W'(w_r) * SLOT_W'(WORD_BITS)
                             + SLOT_W'(hi_bit);
            state_nxt      = S_IDLE;
          end else if ((k_r + AW'(1)) == act_r) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_FULL;
            res_nxt.slot   = slot_r;
            state_nxt      = S_IDLE;
          end else begin
            // Move to the next active word, wrapping at the last one.
            k_nxt     = k_r + AW'(1);
            w_nxt     = ((AW'(w_r) + AW'(1)) == act_r) ? '0 : (w_r + WA'(1));
            state_nxt = S_RD;
          end
        end else begin
          res_nxt.valid = 1'b1;
          res_nxt.slot  = slot_r;
          state_nxt     = S_IDLE;
          if (cmd_r == CMD_ALLOC_AT) begin
            if (is_free) begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata & ~bit_mask;
              res_nxt.status = ST_OK;
            end else begin
              res_nxt.status = ST_TAKEN;
            end
          end else begin
            if (is_free) begin
              res_nxt.status = ST_DOUBLE;
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata | bit_mask;
              res_nxt.status = ST_OK;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new slot count restarts the init sweep and the scan position.
    if (init_req) begin
      state_nxt = S_INIT;
      w_nxt     = '0;
      base_nxt  = '0;
      act_nxt   = '0;
      scan_nxt  = '0;
    end
  end

endmodule

[design/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator: configuration registers, the
// sequencer core and the free-map memory. Depends on bsa_pkg, bsa_core, bsa_map_ram.

// A request is taken when start is high and busy is low; its result appears
// on out_status and out_slot_out for exactly one cycle with out_valid, and the
// receiver cannot stall it. Allocate-any reads one map word at a time through
// the single memory read port (one state to read, one to test and update),
// with busy high while words are scanned; its result appears as busy goes
// low. At most ceil(slot count / WORD_BITS) words are scanned. Allocate-at and
// free split the slot offset into word and bit with a shift and a mask, then
// read and update that word with busy high, and answer as busy goes low.
// Out-of-range slots, the unused command and allocate with no slots answer in
// the cycle after the request and leave busy low. The next request can be
// taken at the edge that ends the result cycle. After reset, and after every
// write of the slot count, a clearing pass writes all MAP_WORDS map words, one
// per cycle, with busy high; writes of the base slot are still taken during it.
// WORD_BITS must be a power of two.
module bitmap_slot_allocator #(
  parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS,
  parameter int MAP_WORDS = bsa_pkg::DEF_MAP_WORDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bsa_pkg::CMD_W-1:0]        in_cmd,
  input  logic [bsa_pkg::SLOT_W-1:0]       in_slot_in,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [bsa_pkg::SLOT_W-1:0]       out_slot_out,
  input  logic                             cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bsa_pkg::*;

  localparam int WA = addr_w(MAP_WORDS);

  logic [SLOT_W-1:0]      slot_base_r, slot_base_nxt;
  logic [NUM_SLOTS_W-1:0] slot_total_r, slot_total_nxt;
  logic                   init_req;
  logic                   ram_we;
  logic [WA-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [WA-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;
  result_t                res;

  // Configuration register writes.
  always_comb begin
    slot_base_nxt  = slot_base_r;
    slot_total_nxt = slot_total_r;
    init_req       = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_SLOT: slot_base_nxt = cfg_data[SLOT_W-1:0];
        CFG_NUM_SLOTS: begin
          slot_total_nxt = cfg_data[NUM_SLOTS_W-1:0];
          init_req       = 1'b1;
        end
        default: begin
          init_req = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_base_r  <= '0;
      slot_total_r <= NUM_SLOTS_W'(4096);
    end else begin
      slot_base_r  <= slot_base_nxt;
      slot_total_r <= slot_total_nxt;
    end
  end

  // Sequencer and datapath.
  bsa_core #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (in_cmd),
    .slot_in    (in_slot_in),
    .slot_base  (slot_base_r),
    .slot_total (slot_total_r),
    .init_req   (init_req),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res        (res)
  );

  // Free-map storage.
  bsa_map_ram #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result ports.
  assign out_valid    = res.valid;
  assign out_status   = res.status;
  assign out_slot_out = res.slot;

`ifndef SYNTHESIS
  // Every accepted request either answers at once or keeps the block busy.
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither answered nor busy");

  // A new slot count always starts the clearing pass.
  a_init_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_NUM_SLOTS)) |=> busy)
    else $error("slot count write did not start the init sweep");

  // The unused command answers out of range in the next cycle.
  a_unknown_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_UNUSED)) |=>
      (out_valid && (out_status == ST_RANGE)))
    else $error("unknown command not answered out of range");
`endif

endmodule

[sim/bsa_checker.sv]
// Result checker for the bitmap slot allocator: keeps its own free map and
// registers, predicts every answer and compares it with what the block returns.
// Depends on bsa_pkg for field widths, command codes and status codes.
module bsa_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [bsa_pkg::CMD_W-1:0]        in_cmd,
  input  logic [bsa_pkg::SLOT_W-1:0]       in_slot_in,
  input  logic                             out_valid,
  input  logic [2:0]                       out_status,
  input  logic [bsa_pkg::SLOT_W-1:0]       out_slot_out,
  input  logic                             cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               compared
);
  import bsa_pkg::*;

  localparam int WB  = DEF_WORD_BITS;
  localparam int MW  = DEF_MAP_WORDS;
  localparam int CAP = WB * MW;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  // Shadow copy of the allocator state and its registers.
  logic [WB-1:0]          free_bits [MW];
  int unsigned            next_word;
  logic [SLOT_W-1:0]      base_slot;
  logic [NUM_SLOTS_W-1:0] slot_count;

  // Answers owed by the block, oldest first.
  answer_t answers_due [$];

  // Slot counts beyond the map capacity are clipped to it.
  function automatic int unsigned live_slots();
    return (slot_count > CAP) ? CAP : slot_count;
  endfunction

  // Free every managed slot, mark the padding used and restart the scan.
  task automatic rebuild_map();
    int unsigned n;
    n = live_slots();
    for (int w = 0; w < MW; w++) begin
      for (int b = 0; b < WB; b++) begin
        free_bits[w][b] = ((w * WB + b) < n);
      end
    end
    next_word = 0;
  endtask

  // Apply one request to the shadow map and work out the answer it earns.
  task automatic serve_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                               output answer_t ans);
    int unsigned       words, first_w, w, hi;
    logic [SLOT_W-1:0] idx;
    logic              granted;
    ans.status = ST_RANGE;
    ans.slot   = slot;
    if (cmd == CMD_ALLOC) begin
      // Next-fit scan from the remembered word, wrapping over the active words.
      words      = (live_slots() + WB - 1) / WB;
      first_w    = (next_word < words) ? next_word : 0;
      ans.status = ST_FULL;
      granted    = 1'b0;
      for (int k = 0; k < words && !granted; k++) begin
        w = (first_w + k) % words;
        if (free_bits[w] != '0) begin
          hi = 0;
          for (int b = 0; b < WB; b++) begin
            if (free_bits[w][b]) hi = b;
          end
          free_bits[w][hi] = 1'b0;
          next_word  = w;
          ans.slot   = base_slot + w * WB + hi;
          ans.status = ST_OK;
          granted    = 1'b1;
        end
      end
    end else if (cmd == CMD_ALLOC_AT || cmd == CMD_FREE) begin
      // The slot offset wraps modulo 2^32, so slots below the base are out of range.
      idx = slot - base_slot;
      if (idx < live_slots()) begin
        w  = idx / WB;
        hi = idx % WB;
        if (cmd == CMD_ALLOC_AT) begin
          if (free_bits[w][hi]) begin
            free_bits[w][hi] = 1'b0;
            ans.status = ST_OK;
          end else begin
            ans.status = ST_TAKEN;
          end
        end else begin
          if (free_bits[w][hi]) begin
            ans.status = ST_DOUBLE;
          end else begin
            free_bits[w][hi] = 1'b1;
            ans.status = ST_OK;
          end
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    compared   = 0;
    pending    = 0;
  end

  // Results are compared before a request taken at the same edge is predicted.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      base_slot  = '0;
      slot_count = NUM_SLOTS_W'(CAP);
      rebuild_map();
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request outstanding: expected none, got status %0d slot %h",
                   $time, out_status, out_slot_out);
        end else begin
          want = answers_due.pop_front();
          compared++;
          if (out_status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_status);
          end
          if (out_slot_out !== want.slot) begin
            fail_count++;
            $display("%0t: slot mismatch: expected %h, got %h",
                     $time, want.slot, out_slot_out);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_SLOT) begin
          base_slot = cfg_data;
        end else if (cfg_index == CFG_NUM_SLOTS) begin
          slot_count = cfg_data[NUM_SLOTS_W-1:0];
          rebuild_map();
        end
      end
      if (start && !busy) begin
        serve_request(in_cmd, in_slot_in, want);
        answers_due.push_back(want);
      end
    end
    pending = answers_due.size();
  end

endmodule

[sim/tb_bitmap_slot_allocator.sv]
// Testbench top for the bitmap slot allocator: clock, reset, register writes and
// request stimulus; the verdict comes from the failure count of bsa_checker.
// Depends on bsa_pkg, bitmap_slot_allocator and bsa_checker.
module tb_bitmap_slot_allocator;
  import bsa_pkg::*;

  localparam int CAPACITY = DEF_WORD_BITS * DEF_MAP_WORDS;
  // The limit covers the worst-case request time over some 830 requests plus the
  // clearing passes several times over.
  localparam int CYCLE_LIMIT = 500000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       in_cmd = CMD_ALLOC;
  logic [SLOT_W-1:0]      in_slot_in = '0;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [SLOT_W-1:0]      out_slot_out;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_FIRST_SLOT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int watch_fails;
  int watch_pending;
  int watch_compared;

  // Stimulus bookkeeping.
  logic                   busy_seen = 1'b1;
  logic [SLOT_W-1:0]      cur_first = '0;
  logic [NUM_SLOTS_W-1:0] cur_count = NUM_SLOTS_W'(CAPACITY);
  int                     idle_pct = 0;
  int                     items = 0;
  int                     settings = 0;
  int                     cycles = 0;

  always #5 clk = ~clk;

  bitmap_slot_allocator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_slot_in   (in_slot_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bsa_checker watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_slot_in   (in_slot_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (watch_fails),
    .pending      (watch_pending),
    .compared     (watch_compared)
  );

  // Busy as it stands just before the next rising edge.
  always @(negedge clk) busy_seen = busy;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold one request until the block takes it; start stays high unless the
  // sender decides to idle afterwards.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_slot_in <= slot;
    do @(posedge clk); while (busy_seen);
    items++;
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding request has been answered.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (watch_pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_FIRST_SLOT) cur_first = data;
    else cur_count = data[NUM_SLOTS_W-1:0];
    settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed requests inside the managed range, with some noise
  // and some slots just past the end.
  task automatic random_request(input int alloc_pct, input int free_pct);
    int unsigned       roll, span;
    logic [SLOT_W-1:0] slot;
    logic [CMD_W-1:0]  cmd;
    span = (cur_count > CAPACITY) ? CAPACITY : cur_count;
    roll = $urandom_range(99, 0);
    slot = (span != 0) ? cur_first + $urandom_range(span - 1, 0) : $urandom;
    if (roll < 8) begin
      cmd  = CMD_W'($urandom_range(3, 0));
      slot = $urandom;
    end else if (roll < 12) begin
      cmd  = roll[0] ? CMD_ALLOC_AT : CMD_FREE;
      slot = cur_first + span + $urandom_range(3, 0);
    end else if (roll < 12 + alloc_pct) begin
      cmd = CMD_ALLOC;
    end else if (roll < 12 + alloc_pct + free_pct) begin
      cmd = CMD_FREE;
    end else begin
      cmd = CMD_ALLOC_AT;
    end
    send(cmd, slot);
  endtask

  initial begin
    logic [SLOT_W-1:0]      pick_first;
    logic [NUM_SLOTS_W-1:0] pick_count;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: base slot zero, the full map of slots.
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC_AT, 32'h0);
    send(CMD_ALLOC_AT, 32'h0);
    send(CMD_FREE, 32'h0);
    send(CMD_FREE, 32'h0);
    send(CMD_ALLOC_AT, 32'd4095);
    send(CMD_ALLOC_AT, 32'd4096);
    send(CMD_FREE, 32'hFFFF_FFFF);
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    send(CMD_UNUSED, 32'h0);
    send(CMD_ALLOC_AT, 32'hAAAA_AAAA);
    send(CMD_FREE, 32'h5555_5555);
    drain();

    // A base near the top of the slot space, so granted slots wrap past zero.
    cfg_write(CFG_FIRST_SLOT, 32'hFFFF_FFF0);
    cfg_write(CFG_NUM_SLOTS, 32'd64);
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC_AT, 32'h0);
    send(CMD_ALLOC_AT, 32'hFFFF_FFEF);
    send(CMD_FREE, 32'h0000_002F);
    drain();

    // No managed slots at all.
    cfg_write(CFG_NUM_SLOTS, 32'd0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_FREE, 32'hFFFF_FFF0);
    drain();

    // Highest base in range and an oversized slot count that is clipped.
    cfg_write(CFG_FIRST_SLOT, 32'hFFFF_EFFF);
    cfg_write(CFG_NUM_SLOTS, 32'h0000_1FFF);
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC_AT, 32'hFFFF_FFFE);
    send(CMD_ALLOC_AT, 32'hFFFF_FFFF);
    drain();

    // A single slot: allocate it, hit full, free it and allocate again.
    cfg_write(CFG_FIRST_SLOT, 32'h0);
    cfg_write(CFG_NUM_SLOTS, 32'd1);
    send(CMD_ALLOC, 32'h0);
    send(CMD_ALLOC, 32'h0);
    send(CMD_FREE, 32'h0);
    send(CMD_ALLOC, 32'h0);
    drain();

    // Random phases, each with its own geometry, sender idling and command mix.
    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 48;
        default: idle_pct = 33;
      endcase
      if (p == 0) pick_first = '0;
      else if (p == 1) pick_first = 32'hFFFF_EFFF;
      else pick_first = $urandom_range(32'hFFFF_EFFF, 0);
      case (p)
        0: pick_count = NUM_SLOTS_W'($urandom_range(40, 1));
        1: pick_count = NUM_SLOTS_W'(CAPACITY);
        2: pick_count = '1;
        3: pick_count = NUM_SLOTS_W'($urandom_range(130, 60));
        4: pick_count = NUM_SLOTS_W'($urandom_range(8, 1));
        5: pick_count = 13'd64;
        6: pick_count = NUM_SLOTS_W'($urandom_range(8191, 0));
        default: pick_count = NUM_SLOTS_W'($urandom_range(300, 100));
      endcase
      drain();
      cfg_write(CFG_FIRST_SLOT, pick_first);
      cfg_write(CFG_NUM_SLOTS, {{(CFG_DATA_W-NUM_SLOTS_W){1'b0}}, pick_count});
      for (int i = 0; i < 100; i++) begin
        // Halfway through, let every outstanding request finish first.
        if (i == 50) drain();
        if (p[0]) random_request(30, 45);
        else random_request(55, 20);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests across %0d register writes; %0d answers compared.",
             items, settings, watch_compared);
    if (watch_fails == 0 && watch_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
